>>> hw/rtl/cfpp_pkg.sv
// Shared types, constants and the byte-wise CRC-16/MCRF4XX update for the frame parser.
// Depends on nothing; cfpp_in_reg, cfpp_parser and the top level import it.
`default_nettype none

package cfpp_pkg;

  // Configuration register indexes on the write port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam int unsigned CfgDataW = 11;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [10:0] MAX_LENGTH_RST  = 11'd1024;

  // CRC start value.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LENH  = 3'd2,
    PH_LENL  = 3'd3,
    PH_ID    = 3'd4,
    PH_DATA  = 3'd5,
    PH_CRCH  = 3'd6,
    PH_CRCL  = 3'd7
  } phase_e;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_BYTE = 3'd1,
    EV_OK   = 3'd2,
    EV_CRC  = 3'd3,
    EV_LONG = 3'd4
  } event_e;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [10:0] max_length;
  } cfg_t;

  // Input register contents handed to the parser.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } in_stage_t;

  // One byte of CRC-16/MCRF4XX (reflected polynomial 0x8408).
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfpp_rx_if.sv
// Received-byte channel: valid/ready handshake carrying one byte per transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface cfpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cfpp_ev_if.sv
// Result channel: valid/ready handshake carrying one parser event per transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface cfpp_ev_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic [15:0] frame_length;
  logic [7:0]  frame_id;

  modport source (
    output valid, output event_res, output payload_byte, output payload_index,
    output frame_length, output frame_id, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input payload_index,
    input frame_length, input frame_id, output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/cfpp_in_reg.sv
// Input register of the frame parser: holds one received byte until the parser takes it.
// Depends on cfpp_pkg and cfpp_rx_if.
`default_nettype none

module cfpp_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  cfpp_rx_if.sink              rx,
  input  wire logic            take_i,
  output cfpp_pkg::in_stage_t  stage_o
);
  import cfpp_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] data_q;
  logic       accept;

  // The register is free when empty or when its byte moves on in this cycle.
  assign rx.ready = !vld_q || take_i;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload capture on each transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx.rx_byte;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.data = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/cfpp_parser.sv
// Frame parser state machine, CRC accumulator and result register.
// Depends on cfpp_pkg and cfpp_ev_if.
`default_nettype none

module cfpp_parser #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  cfpp_pkg::cfg_t       cfg_i,
  input  cfpp_pkg::in_stage_t  stage_i,
  output logic                 take_o,
  cfpp_ev_if.source            res
);
  import cfpp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxPayload = 16'(MAX_PAYLOAD);

  // Parser state.
  phase_e        phase_q, phase_d;
  logic [15:0]   crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]   len_q, len_d;
  logic [7:0]    id_q, id_d;

  // Result register.
  logic          ov_q;
  event_e        ev_q, ev_d;
  logic [7:0]    pbyte_q, pbyte_d;
  logic [9:0]    pidx_q, pidx_d;

  logic [7:0]    b;
  logic [15:0]   crc_upd;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]   cnt_ext;
  logic [15:0]   len_low;
  logic          too_long;

  // A byte is processed when the result register is empty or being drained.
  assign take_o = stage_i.vld && (!ov_q || res.ready);

  assign b       = stage_i.data;
  assign crc_upd = crc_step(b, crc_q);
  assign cnt_inc = cnt_q + 1'b1;
  assign cnt_ext = 16'(cnt_q);
  assign len_low = {len_q[15:8], b};
  // Above the smaller of the two limits means above either of them.
  assign too_long = (len_low > {5'b0, cfg_i.max_length}) || (len_low > MaxPayload);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SYNC1: if (b == cfg_i.sync_first) phase_d = PH_SYNC2;
      PH_SYNC2: if (b == cfg_i.sync_second) phase_d = PH_LENH;
      PH_LENH:  phase_d = PH_LENL;
      PH_LENL:  phase_d = too_long ? PH_SYNC1 : PH_ID;
      PH_ID:    phase_d = (len_q != 16'h0000) ? PH_DATA : PH_CRCH;
      PH_DATA:  if (16'(cnt_inc) >= len_q) phase_d = PH_CRCH;
      PH_CRCH:  phase_d = (b == crc_q[15:8]) ? PH_CRCL : PH_SYNC1;
      PH_CRCL:  phase_d = PH_SYNC1;
    endcase
  end

  // Datapath and result for the current byte.
  always_comb begin
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    id_d    = id_q;
    ev_d    = EV_NONE;
    pbyte_d = 8'h00;
    pidx_d  = 10'h000;
    unique case (phase_q)
      PH_SYNC1: ;
      PH_SYNC2: begin
        if (b == cfg_i.sync_second) begin
          crc_d = CRC_INIT;
          len_d = 16'h0000;
          id_d  = 8'h00;
        end
      end
      PH_LENH: begin
        len_d = {b, 8'h00};
        crc_d = crc_upd;
      end
      PH_LENL: begin
        len_d = len_low;
        crc_d = crc_upd;
        if (too_long) ev_d = EV_LONG;
      end
      PH_ID: begin
        id_d  = b;
        crc_d = crc_upd;
        cnt_d = '0;
      end
      PH_DATA: begin
        ev_d    = EV_BYTE;
        pbyte_d = b;
        pidx_d  = cnt_ext[9:0];
        crc_d   = crc_upd;
        cnt_d   = cnt_inc;
      end
      PH_CRCH: begin
        if (b != crc_q[15:8]) ev_d = EV_CRC;
      end
      PH_CRCL: begin
        ev_d = (b == crc_q[7:0]) ? EV_OK : EV_CRC;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      crc_q   <= CRC_INIT;
      cnt_q   <= '0;
      len_q   <= 16'h0000;
      id_q    <= 8'h00;
    end else if (take_o) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      id_q    <= id_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (take_o) begin
      ov_q <= 1'b1;
    end else if (res.ready) begin
      ov_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      ev_q    <= ev_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
    end
  end

  // Length and id follow the state, which only moves when the result is replaced.
  assign res.valid         = ov_q;
  assign res.event_res     = ev_q;
  assign res.payload_byte  = pbyte_q;
  assign res.payload_index = pidx_q;
  assign res.frame_length  = len_q;
  assign res.frame_id      = id_q;

  // A forwarded byte always lies inside the frame's length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ev_q == EV_BYTE) |-> ({6'b0, pidx_q} < len_q))
    else $error("payload index outside frame length");

  // Events that end a frame leave the parser hunting again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (ev_q == EV_OK || ev_q == EV_CRC || ev_q == EV_LONG)) |-> (phase_q == PH_SYNC1))
    else $error("frame ended without returning to sync hunt");

  // While in the payload the count stays below a nonzero length within the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (len_q != 16'h0000 && cnt_ext < len_q && len_q <= MaxPayload))
    else $error("payload counter out of range");

  // Processing a byte always leaves a result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> ov_q)
    else $error("processed byte produced no result");

endmodule

`default_nettype wire

>>> hw/rtl/crc16_framed_packet_parser_core.sv
// Top level of the CRC-16 framed packet parser: configuration registers, input register
// and parser. Depends on cfpp_pkg, cfpp_rx_if, cfpp_ev_if, cfpp_in_reg and cfpp_parser.
// A transferred byte is first registered in the input register; the parser then writes
// its result into the result register, from which the result transfer is offered.
// Throughput: one byte per cycle unless stalled; CRC and phase update are combinational.
// The input register and the result register each hold one item; while a finished result
// waits on the output, one more byte is taken and then the input stalls.
// Reset (asynchronous, active low) restores sync bytes 0xAA/0x55, maximum length 1024,
// the sync hunt, CRC 0xFFFF and cleared length and id; no clearing pass is needed.
`default_nettype none

module crc16_framed_packet_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cfpp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [cfpp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  cfpp_rx_if.sink                               rx,
  cfpp_ev_if.source                             res
);
  import cfpp_pkg::*;

  cfg_t      cfg_q, cfg_d;
  in_stage_t stage;
  logic      take;

  // Configuration register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  cfg_d.sync_first  = cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: cfg_d.sync_second = cfg_wdata_i[7:0];
        CFG_MAX_LENGTH:  cfg_d.max_length  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_length  <= MAX_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register.
  cfpp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx      (rx),
    .take_i  (take),
    .stage_o (stage)
  );

  // Parser and result register.
  cfpp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .stage_i (stage),
    .take_o  (take),
    .res     (res)
  );

endmodule

`default_nettype wire
